@@ rtl/mmod_pkg.sv @@
`default_nettype none
package mmod_pkg;

  // Widths of the intermediate values (Q32.32 raw for sums, Q16.16 for the root).
  localparam int unsigned SumW  = 68;  // trace B + 2|det A|, never negative
  localparam int unsigned RootW = 34;  // floor(sqrt(S))
  localparam int unsigned RemW  = 36;  // square root partial remainder
  localparam int unsigned NumW  = 67;  // signed numerators
  localparam int unsigned DRemW = 35;  // division partial remainder
  localparam int unsigned QW    = 32;  // quotient bits produced by the chain
  localparam int unsigned Lanes = 4;

  localparam logic [QW-1:0] QPosMax = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] QNegMax = 32'h8000_0000;

  localparam logic [2:0] AddrLimit = 3'd0;

  // Word travelling down the square root chain.
  typedef struct packed {
    logic                             valid;
    logic [SumW-1:0]                  v;
    logic [RootW-1:0]                 root;
    logic [RemW-1:0]                  rem;
    logic [Lanes-1:0][NumW-1:0]       n;
  } sq_t;

  // Word travelling down the division chain, one lane per matrix entry.
  typedef struct packed {
    logic                             valid;
    logic                             degen;
    logic [RootW-1:0]                 s;
    logic [Lanes-1:0]                 neg;
    logic [Lanes-1:0]                 big;
    logic [Lanes-1:0][DRemW-1:0]      rem;
    logic [Lanes-1:0][QW-1:0]         lo;
    logic [Lanes-1:0][QW-1:0]         q;
  } dv_t;

endpackage
`default_nettype wire

@@ rtl/mmod_front.sv @@
`default_nettype none
module mmod_front
  import mmod_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [Lanes-1:0][31:0] a,
  output sq_t                        o_d
);

  logic signed [31:0] a00, a01, a10, a11;
  logic signed [63:0] m_r [8];
  logic signed [64:0] b00_r, b01_r, b10_r, b11_r;
  logic        [64:0] bb_r;
  logic signed [64:0] det;
  logic [SumW-1:0]    s_r;
  logic [Lanes-1:0][NumW-1:0] n_r;
  logic [68:0]        s_sum;
  logic [2:0]         vld_r;

  assign a00 = a[0];
  assign a01 = a[1];
  assign a10 = a[2];
  assign a11 = a[3];
  assign det = {m_r[7][63], m_r[7]} - {m_r[1][63], m_r[1]};
  assign s_sum = {{4{b00_r[64]}}, b00_r} + {{4{b11_r[64]}}, b11_r} + {3'b000, bb_r, 1'b0};

  // Stage one: the eight distinct products; stage two: entries of B and |det A|; stage three: S and the numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= a00 * a00;
      m_r[1] <= a01 * a10;
      m_r[2] <= a00 * a01;
      m_r[3] <= a01 * a11;
      m_r[4] <= a10 * a00;
      m_r[5] <= a11 * a10;
      m_r[6] <= a11 * a11;
      m_r[7] <= a00 * a11;
      b00_r  <= {m_r[0][63], m_r[0]} + {m_r[1][63], m_r[1]};
      b01_r  <= {m_r[2][63], m_r[2]} + {m_r[3][63], m_r[3]};
      b10_r  <= {m_r[4][63], m_r[4]} + {m_r[5][63], m_r[5]};
      b11_r  <= {m_r[1][63], m_r[1]} + {m_r[6][63], m_r[6]};
      bb_r   <= det[64] ? 65'(-det) : det;
      s_r    <= s_sum[SumW-1:0];
      n_r[0] <= {{2{b00_r[64]}}, b00_r} + {2'b00, bb_r};
      n_r[1] <= {{2{b01_r[64]}}, b01_r};
      n_r[2] <= {{2{b10_r[64]}}, b10_r};
      n_r[3] <= {{2{b11_r[64]}}, b11_r} + {2'b00, bb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_comb begin
    o_d.valid = vld_r[2];
    o_d.v     = s_r;
    o_d.root  = '0;
    o_d.rem   = '0;
    o_d.n     = n_r;
  end

endmodule
`default_nettype wire

@@ rtl/mmod_sqrt_cell.sv @@
`default_nettype none
module mmod_sqrt_cell
  import mmod_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire sq_t  i_d,
  output sq_t       o_d
);

  logic [RemW+1:0] rs, trial, diff;
  logic            ge;
  sq_t             nxt, data_r;
  logic            vld_r;

  // One root bit per cell: bring in the next two radicand bits and try the bit.
  always_comb begin
    rs         = {i_d.rem, i_d.v[SumW-1 -: 2]};
    trial      = {2'b00, i_d.root, 2'b01};
    ge         = rs >= trial;
    diff       = rs - trial;
    nxt        = i_d;
    nxt.v      = {i_d.v[SumW-3:0], 2'b00};
    nxt.root   = {i_d.root[RootW-2:0], ge};
    nxt.rem    = ge ? diff[RemW-1:0] : rs[RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_d.valid;
    end
  end

  always_comb begin
    o_d       = data_r;
    o_d.valid = vld_r;
  end

endmodule
`default_nettype wire

@@ rtl/mmod_div_cell.sv @@
`default_nettype none
module mmod_div_cell
  import mmod_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire dv_t  i_d,
  output dv_t       o_d
);

  logic [DRemW:0] rs [Lanes];
  logic [DRemW:0] diff [Lanes];
  logic [Lanes-1:0] ge;
  dv_t nxt, data_r;
  logic vld_r;

  // One quotient bit per lane per cell, restoring division by the root.
  always_comb begin
    nxt = i_d;
    for (int l = 0; l < Lanes; l++) begin
      rs[l]      = {i_d.rem[l], i_d.lo[l][QW-1]};
      ge[l]      = rs[l] >= {2'b00, i_d.s};
      diff[l]    = rs[l] - {2'b00, i_d.s};
      nxt.rem[l] = ge[l] ? diff[l][DRemW-1:0] : rs[l][DRemW-1:0];
      nxt.lo[l]  = {i_d.lo[l][QW-2:0], 1'b0};
      nxt.q[l]   = {i_d.q[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_d.valid;
    end
  end

  always_comb begin
    o_d       = data_r;
    o_d.valid = vld_r;
  end

endmodule
`default_nettype wire

@@ rtl/matrix_modulus_2x2_top.sv @@
// Modulus |A| = sqrt(A*A) of a 2x2 signed Q16.16 matrix, one matrix per cycle unless stalled.
// Input stream: in_tdata carries a00, a01, a10, a11 (32 bits each, a00 lowest).
// Result stream: out_tdata carries m00, m01, m10, m11 and out_tuser carries the
// degenerate flag (bit 0) and the saturated flag (bit 1).
// The APB port holds one register, small_limit, at byte address 0; a root at or
// below it gives the zero matrix with the degenerate flag set.
// An input word passes the registered products and sums of the front end, a
// chain of 34 square root cells (one root bit each), a register of sign and
// range preparation, a chain of 32 division cells (one quotient bit of all
// four entries each) and the output register, in that order.
// Throughput is one matrix per cycle while en is high; every cell hands its word on each such cycle.
// The result register is backed by a one-entry skid buffer, so in_tready only
// falls once a result is parked there while the receiver holds out_tready low;
// the whole chain then freezes until the receiver takes a transfer.
// Synchronous reset empties the chain and the output stage and clears
// small_limit to zero.
`default_nettype none
module matrix_modulus_2x2_top
  import mmod_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a00, a01, a10, a11
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // m00, m01, m10, m11
  output logic [1:0]        out_tuser,  // degenerate, saturated
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned SqCells = RootW;
  localparam int unsigned DvCells = QW;

  logic [15:0] limit_r;
  logic        en;
  logic [Lanes-1:0][31:0] a_in;

  sq_t sq_chain [SqCells+1];
  dv_t dv_chain [DvCells+1];
  dv_t prep_nxt, prep_r;
  logic prep_vld_r;

  logic [NumW-1:0] mag [Lanes];
  logic            pipe_valid;
  logic [127:0]    pipe_data;
  logic [1:0]      pipe_user;
  logic            out_valid_r, skid_valid_r;
  logic [127:0]    out_data_r, skid_data_r;
  logic [1:0]      out_user_r, skid_user_r;

  // Configuration port: writes complete in the access phase, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {16'h0000, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == AddrLimit[2]) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  // The chain advances whenever the skid buffer has room.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  assign a_in[0] = in_tdata[31:0];
  assign a_in[1] = in_tdata[63:32];
  assign a_in[2] = in_tdata[95:64];
  assign a_in[3] = in_tdata[127:96];

  mmod_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid && in_tready),
    .a        (a_in),
    .o_d      (sq_chain[0])
  );

  for (genvar j = 0; j < SqCells; j++) begin : g_sq
    mmod_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .i_d   (sq_chain[j]),
      .o_d   (sq_chain[j+1])
    );
  end

  // Preparation: compare the root with the limit, take magnitudes and check
  // whether any quotient reaches 2^32 before the division chain starts.
  always_comb begin
    prep_nxt       = '0;
    prep_nxt.valid = sq_chain[SqCells].valid;
    prep_nxt.s     = sq_chain[SqCells].root;
    prep_nxt.degen = sq_chain[SqCells].root <= {18'd0, limit_r};
    for (int l = 0; l < Lanes; l++) begin
      prep_nxt.neg[l] = sq_chain[SqCells].n[l][NumW-1];
      mag[l] = prep_nxt.neg[l] ? NumW'(-sq_chain[SqCells].n[l]) : sq_chain[SqCells].n[l];
      prep_nxt.big[l] = mag[l][NumW-1:QW] >= {1'b0, sq_chain[SqCells].root};
      prep_nxt.rem[l] = prep_nxt.big[l] ? '0 : mag[l][NumW-1:QW];
      prep_nxt.lo[l]  = mag[l][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= prep_nxt.valid;
    end
  end

  always_comb begin
    dv_chain[0]       = prep_r;
    dv_chain[0].valid = prep_vld_r;
  end

  for (genvar j = 0; j < DvCells; j++) begin : g_dv
    mmod_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .i_d   (dv_chain[j]),
      .o_d   (dv_chain[j+1])
    );
  end

  // Sign, saturation and the degenerate case on the last division word.
  always_comb begin
    logic [QW-1:0] q;
    logic          ovf;
    logic          sat_any;
    sat_any   = 1'b0;
    pipe_data = '0;
    for (int l = 0; l < Lanes; l++) begin
      q   = dv_chain[DvCells].q[l];
      ovf = dv_chain[DvCells].big[l] ||
            (dv_chain[DvCells].neg[l] ? (q > QNegMax) : (q > QPosMax));
      if (dv_chain[DvCells].degen) begin
        pipe_data[l*32 +: 32] = '0;
      end else if (ovf) begin
        sat_any = 1'b1;
        pipe_data[l*32 +: 32] = dv_chain[DvCells].neg[l] ? QNegMax : QPosMax;
      end else begin
        pipe_data[l*32 +: 32] = dv_chain[DvCells].neg[l] ? QW'(-q) : q;
      end
    end
    pipe_valid = dv_chain[DvCells].valid;
    pipe_user  = {sat_any, dv_chain[DvCells].degen};
  end

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || (en && pipe_valid);
      skid_valid_r <= 1'b0;
    end else if (en && pipe_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : pipe_data;
      out_user_r <= skid_valid_r ? skid_user_r : pipe_user;
    end else if (en && pipe_valid) begin
      skid_data_r <= pipe_data;
      skid_user_r <= pipe_user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && out_tdata == '0)
    else $error("degenerate result is not the clean zero matrix");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tready && pipe_valid |=> !in_tready)
    else $error("stalled result was not parked in the skid buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_tready |=> !skid_valid_r && out_valid_r)
    else $error("skid entry not moved on after a transfer");
`endif

endmodule
`default_nettype wire

@@ tb/tb_matrix_modulus_2x2_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix_modulus_2x2_top
  import mmod_pkg::*;
();

  // One expected modulus result: four Q16.16 entries and the two flags.
  typedef struct {
    logic [31:0] m [4];
    logic        degen;
    logic        sat;
  } modulus_t;

  localparam int unsigned Latency    = 71;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned RandPerSet = 160;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;     // a00, a01, a10, a11 from the lowest bit up
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;    // m00, m01, m10, m11 from the lowest bit up
  logic [1:0]   out_tuser;    // degenerate, saturated from the lowest bit up
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  matrix_modulus_2x2_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Matrices waiting to be offered, and the moduli still owed by the block.
  logic [127:0] matrix_queue [$];
  modulus_t     modulus_queue [$];

  logic [15:0]  limit_copy;      // our copy of small_limit
  int unsigned  send_idle_pct;   // chance in a hundred that the sender idles
  int unsigned  recv_stall_pct;  // chance in a hundred that the receiver stalls
  int unsigned  hold_request;    // cycles of forced receiver hold-off still asked for
  int unsigned  hold_left;
  int unsigned  idle_cycles;
  int unsigned  n_results;
  int unsigned  n_degen;
  int unsigned  n_sat;
  int unsigned  n_errors;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Divides a Q32.32 numerator by the Q16.16 root, rounding toward zero and
  // clipping to the signed 32-bit range.
  function automatic logic [31:0] quotient_sat(input logic signed [127:0] num,
                                               input logic [33:0] root,
                                               inout logic sat);
    logic          neg;
    logic [127:0]  mag;
    logic [127:0]  q;
    neg = num[127];
    mag = neg ? -num : num;
    q   = mag / {94'd0, root};
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return QNegMax;
      end
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return QPosMax;
    end
    return q[31:0];
  endfunction

  // Works out |A| for one matrix under the current limit.
  function automatic modulus_t predict_modulus(input logic [127:0] a);
    logic signed [127:0] x00, x01, x10, x11;
    logic signed [127:0] b00, b01, b10, b11, det, absdet, total;
    logic [127:0]        cand2;
    logic [33:0]         root;
    logic [33:0]         cand;
    modulus_t            r;
    logic                sat;
    x00 = $signed(a[31:0]);
    x01 = $signed(a[63:32]);
    x10 = $signed(a[95:64]);
    x11 = $signed(a[127:96]);
    b00 = x00 * x00 + x01 * x10;
    b01 = x00 * x01 + x01 * x11;
    b10 = x10 * x00 + x11 * x10;
    b11 = x10 * x01 + x11 * x11;
    det = x00 * x11 - x01 * x10;
    absdet = det[127] ? -det : det;
    total = b00 + b11 + 2 * absdet;
    root = '0;
    for (int k = 33; k >= 0; k--) begin
      cand  = root | (34'd1 << k);
      cand2 = {94'd0, cand} * {94'd0, cand};
      if (cand2 <= total) root = cand;
    end
    sat = 1'b0;
    if (root <= {18'd0, limit_copy}) begin
      for (int i = 0; i < 4; i++) r.m[i] = '0;
      r.degen = 1'b1;
      r.sat   = 1'b0;
      return r;
    end
    r.m[0] = quotient_sat(b00 + absdet, root, sat);
    r.m[1] = quotient_sat(b01, root, sat);
    r.m[2] = quotient_sat(b10, root, sat);
    r.m[3] = quotient_sat(b11 + absdet, root, sat);
    r.degen = 1'b0;
    r.sat   = sat;
    return r;
  endfunction

  // Sender: a new matrix is offered only once the previous one has been taken,
  // so tvalid stays up across back-to-back transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (matrix_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= matrix_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request so
  // that the chain fills up and in_tready falls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_request;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_request <= 0;
  end

  // Monitor: predicts at each input transfer and checks each result transfer
  // against the oldest outstanding modulus.
  always @(posedge clk) begin
    modulus_t want;
    logic [31:0] got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        modulus_queue.insert(modulus_queue.size(), predict_modulus(in_tdata));
      if (out_tvalid && out_tready) begin
        if (modulus_queue.size() == 0) begin
          $error("result transfer with no modulus outstanding");
          n_errors++;
        end else begin
          want = modulus_queue.pop_front();
          n_results++;
          if (want.degen) n_degen++;
          if (want.sat) n_sat++;
          for (int i = 0; i < 4; i++) begin
            got = out_tdata[32*i +: 32];
            if (got !== want.m[i]) begin
              $error("m%0d%0d: expected %h, got %h", i / 2, i % 2, want.m[i], got);
              n_errors++;
            end
          end
          if (out_tuser[0] !== want.degen) begin
            $error("degenerate: expected %b, got %b", want.degen, out_tuser[0]);
            n_errors++;
          end
          if (out_tuser[1] !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, out_tuser[1]);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [127:0] pack_matrix(input logic [31:0] a00, input logic [31:0] a01,
                                               input logic [31:0] a10, input logic [31:0] a11);
    return {a11, a10, a01, a00};
  endfunction

  // Appends one matrix to the tail of the sender's queue.
  function automatic void queue_matrix(input logic [127:0] m);
    matrix_queue.insert(matrix_queue.size(), m);
  endfunction

  // One random entry: full-range words, small values within two units of zero,
  // or values within 256 units so that limits and saturation are reached in turn.
  function automatic logic [31:0] random_entry(input int unsigned style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  task automatic add_random_matrices(input int unsigned count);
    int unsigned style;
    logic [31:0] e [4];
    for (int n = 0; n < count; n++) begin
      style = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) e[i] = random_entry(style);
      // Now and then a symmetric or a diagonal matrix, or, where a00 is zero,
      // one whose diagonal is zero.
      case ($urandom_range(0, 5))
        0: e[3] = e[0] == 0 ? 32'd0 : e[3];
        1: e[2] = e[1];
        2: begin e[2] = 32'd0; e[1] = 32'd0; end
        default: ;
      endcase
      queue_matrix(pack_matrix(e[0], e[1], e[2], e[3]));
    end
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AddrLimit;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    limit_copy = value[15:0];
  endtask

  // Waits until every matrix has been taken and every modulus has come back,
  // then lets the chain run dry before anything else happens.
  task automatic drain;
    while (matrix_queue.size() > 0 || in_tvalid || modulus_queue.size() > 0)
      @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    limit_copy     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    n_results      = 0;
    n_degen        = 0;
    n_sat          = 0;
    n_errors       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed set under the reset limit of zero: the zero matrix (root of
    // zero is degenerate), the identity, extreme entries that overflow, and
    // sign patterns.
    queue_matrix(pack_matrix(32'd0, 32'd0, 32'd0, 32'd0));
    queue_matrix(pack_matrix(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000));
    queue_matrix(pack_matrix(32'hFFFF_0000, 32'd0, 32'd0, 32'h0001_0000));
    queue_matrix(pack_matrix(32'hFFFF_0000, 32'd0, 32'd0, 32'hFFFF_0000));
    queue_matrix(pack_matrix(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0));
    queue_matrix(pack_matrix(32'h8000_0000, 32'd0, 32'd0, 32'd0));
    queue_matrix(pack_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF));
    queue_matrix(pack_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000));
    queue_matrix(pack_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF));
    queue_matrix(pack_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF));
    queue_matrix(pack_matrix(32'd1, 32'd0, 32'd0, 32'd0));
    queue_matrix(pack_matrix(32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0));
    queue_matrix(pack_matrix(32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0));
    queue_matrix(pack_matrix(32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                             32'h0002_0000));
    queue_matrix(pack_matrix(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'hAAAA_AAAA));
    queue_matrix(pack_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h5555_5555));
    queue_matrix(pack_matrix(32'h0000_8000, 32'd0, 32'd0, 32'h0000_8000));
    drain();

    // Largest limit: anything with a root below one unit comes back as zeros.
    write_limit(32'hFFFF_FFFF);
    queue_matrix(pack_matrix(32'h0000_FFFF, 32'd0, 32'd0, 32'h0000_FFFF));
    queue_matrix(pack_matrix(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000));
    queue_matrix(pack_matrix(32'h0001_0001, 32'd0, 32'd0, 32'd0));
    add_random_matrices(RandPerSet);
    drain();

    // Sender idling under a mid limit.
    send_idle_pct = 61;
    write_limit($urandom_range(1, 65534));
    add_random_matrices(RandPerSet);
    drain();

    // Receiver stalling with the smallest non-zero limit.
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    write_limit(32'd1);
    add_random_matrices(RandPerSet);
    drain();

    // Both sides idling now and then.
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    write_limit($urandom_range(0, 65535));
    add_random_matrices(RandPerSet);
    drain();

    // Back to a zero limit at full rate, with one long hold-off on the result
    // side while the sender keeps offering, so that the chain backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_limit(32'd0);
    add_random_matrices(RandPerSet);
    repeat (20) @(posedge clk);
    hold_request = 300;
    drain();

    $display("Checked %0d moduli (%0d degenerate, %0d saturated) over six limit settings,",
             n_results, n_degen, n_sat);
    $display("with sender idling, receiver stalls and one long result hold-off.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
